// ===== rtl/core/ilie_pkg.sv =====
// shared types and constants for the indexed list with insert and erase
// depends on nothing; used by the controller, datapath and top level
`timescale 1ns / 1ps

package ilie_pkg;

  // fixed field widths of the command and result beats
  localparam int CMD_W = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int CNT_W = 5;

  // default list geometry
  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_WRITE  = 3'd4
  } cmd_e;

  // datapath micro-operations issued by the controller
  typedef enum logic [3:0] {
    UOP_NONE      = 4'd0,
    UOP_LOAD      = 4'd1,
    UOP_APPEND    = 4'd2,
    UOP_WRITE     = 4'd3,
    UOP_READ      = 4'd4,
    UOP_CAPTURE   = 4'd5,
    UOP_INS_START = 4'd6,
    UOP_INS_MOVE  = 4'd7,
    UOP_INS_PUT   = 4'd8,
    UOP_ERS_START = 4'd9,
    UOP_ERS_MOVE  = 4'd10,
    UOP_ERS_DROP  = 4'd11
  } uop_e;

  // status from datapath to controller
  typedef struct packed {
    cmd_e cmd;         // latched command
    logic legal;       // command may succeed against the current list
    logic ins_at_end;  // insert position equals the length
    logic ers_at_end;  // erase position is the last entry
    logic at_pos;      // shift read index reached the position
    logic at_last;     // shift read index reached the last entry
  } sts_t;

endpackage

// ===== rtl/core/indexed_list_insert_erase.sv =====
// top level of the indexed list with insert and erase
// depends on ilie_pkg, ilie_ctrl, ilie_datapath (and ilie_ram below it)
//
//   beat      direction  handshake               payload
//   command   in         start && !busy          cmd_i, pos_i, value_i
//   result    out        done_o (one cycle)      ok_o, read_data_o, count_o
//
// the result strobe follows the check state for append, write, insert at the end
// and failed commands; a read first waits for the ram data, an insert in the middle
// first shifts entries up and an erase first shifts later entries down; busy is
// still high with the strobe, drops in the cycle after it and a command is taken then
// the shift moves one entry per cycle through the ram's one read port and one write port
// reset clears the length and the controller; entries stay undefined until written
// results cannot be stalled by the receiver
`timescale 1ns / 1ps

module indexed_list_insert_erase #(
  parameter int DEPTH = ilie_pkg::DEPTH_DEF,
  parameter int WIDTH = ilie_pkg::WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ilie_pkg::CMD_W-1:0] cmd_i,
  input  logic [ilie_pkg::POS_W-1:0] pos_i,
  input  logic [ilie_pkg::VAL_W-1:0] value_i,
  output logic                       done_o,
  output logic                       ok_o,
  output logic [ilie_pkg::VAL_W-1:0] read_data_o,
  output logic [ilie_pkg::CNT_W-1:0] count_o
);

  import ilie_pkg::*;

  uop_e uop;
  sts_t sts;

  // sequencer
  ilie_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .uop_o   (uop),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // storage and result registers
  ilie_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_i       (uop),
    .cmd_i       (cmd_i),
    .pos_i       (pos_i),
    .value_i     (value_i),
    .sts_o       (sts),
    .ok_o        (ok_o),
    .read_data_o (read_data_o),
    .count_o     (count_o)
  );

  // an accepted command keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // one result beat per command, never back to back
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // a failed command returns zero read data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (read_data_o == '0))
    else $error("failed command returned read data");

endmodule

// ===== rtl/core/ilie_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module ilie_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ilie_datapath.sv =====
// datapath: command latch, list length, shift index, entry ram and result registers
// depends on ilie_pkg and ilie_ram
`timescale 1ns / 1ps

module ilie_datapath #(
  parameter int DEPTH = ilie_pkg::DEPTH_DEF,
  parameter int WIDTH = ilie_pkg::WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ilie_pkg::uop_e              uop_i,
  input  logic [ilie_pkg::CMD_W-1:0]  cmd_i,
  input  logic [ilie_pkg::POS_W-1:0]  pos_i,
  input  logic [ilie_pkg::VAL_W-1:0]  value_i,
  output ilie_pkg::sts_t              sts_o,
  output logic                        ok_o,
  output logic [ilie_pkg::VAL_W-1:0]  read_data_o,
  output logic [ilie_pkg::CNT_W-1:0]  count_o
);

  import ilie_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [AW-1:0] ONE_A = AW'(1);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  cmd_e             cmd_q;
  logic [POS_W-1:0] pos_q;
  logic [WIDTH-1:0] val_q;
  logic [CW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;
  logic             ok_q, ok_d;
  logic [WIDTH-1:0] res_q, res_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WIDTH-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [WIDTH-1:0] ram_rdata;

  logic [XW-1:0]    pos_x;
  logic [XW-1:0]    fill_x;
  logic             full;

  // widened operands for position checks
  assign pos_x  = XW'(pos_q);
  assign fill_x = XW'(fill_q);
  assign full   = (fill_q == CW'(DEPTH));

  // legality and shift-end status
  always_comb begin
    sts_o.cmd = cmd_q;
    case (cmd_q)
      CMD_APPEND: sts_o.legal = !full;
      CMD_INSERT: sts_o.legal = !full && (pos_x <= fill_x);
      CMD_ERASE,
      CMD_READ,
      CMD_WRITE:  sts_o.legal = (pos_x < fill_x);
      default:    sts_o.legal = 1'b0;
    endcase
    sts_o.ins_at_end = (pos_x == fill_x);
    sts_o.ers_at_end = ((XW+1)'(pos_x) + (XW+1)'(1)) == (XW+1)'(fill_x);
    sts_o.at_pos     = (XW'(rd_idx_q) == pos_x);
    sts_o.at_last    = ((CW'(rd_idx_q) + ONE_C) == fill_q);
  end

  // ram port control and next state per micro-operation
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(fill_q);
    ram_wdata = val_q;
    ram_raddr = rd_idx_q;
    rd_idx_d  = rd_idx_q;
    fill_d    = fill_q;
    ok_d      = ok_q;
    res_d     = res_q;
    case (uop_i)
      UOP_LOAD: begin
        ok_d  = 1'b0;
        res_d = '0;
      end
      UOP_APPEND: begin
        ram_we = 1'b1;
        fill_d = fill_q + ONE_C;
        ok_d   = 1'b1;
      end
      UOP_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_q);
        ok_d      = 1'b1;
      end
      UOP_READ: begin
        ram_raddr = AW'(pos_q);
      end
      UOP_CAPTURE: begin
        res_d = ram_rdata;
        ok_d  = 1'b1;
      end
      UOP_INS_START: begin
        ram_raddr = AW'(fill_q - ONE_C);
        rd_idx_d  = ram_raddr;
      end
      UOP_INS_MOVE: begin
        // move entry up by one, fetch the next lower entry
        ram_we    = 1'b1;
        ram_waddr = rd_idx_q + ONE_A;
        ram_wdata = ram_rdata;
        ram_raddr = rd_idx_q - ONE_A;
        rd_idx_d  = ram_raddr;
      end
      UOP_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_q);
        fill_d    = fill_q + ONE_C;
        ok_d      = 1'b1;
      end
      UOP_ERS_START: begin
        ram_raddr = AW'(pos_q) + ONE_A;
        rd_idx_d  = ram_raddr;
      end
      UOP_ERS_MOVE: begin
        // move entry down by one, fetch the next higher entry
        ram_we    = 1'b1;
        ram_waddr = rd_idx_q - ONE_A;
        ram_wdata = ram_rdata;
        ram_raddr = rd_idx_q + ONE_A;
        rd_idx_d  = ram_raddr;
      end
      UOP_ERS_DROP: begin
        fill_d = fill_q - ONE_C;
        ok_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ok_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ok_q   <= ok_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (uop_i == UOP_LOAD) begin
      cmd_q <= cmd_e'(cmd_i);
      pos_q <= pos_i;
      val_q <= WIDTH'(value_i);
    end
    rd_idx_q <= rd_idx_d;
    res_q    <= res_d;
  end

  // entry storage
  ilie_ram #(
    .W (WIDTH),
    .D (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ok_o        = ok_q;
  assign read_data_o = VAL_W'(res_q);
  assign count_o     = CNT_W'(fill_q);

  // length stays within capacity
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("list length above capacity");

  // writes land inside the list or at its open end
  a_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) <= fill_q))
    else $error("ram write beyond list end");

endmodule

// ===== rtl/core/ilie_ctrl.sv =====
// controller: one-hot state machine sequencing checks, shifts and the result beat
// depends on ilie_pkg
`timescale 1ns / 1ps

module ilie_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ilie_pkg::sts_t sts_i,
  output ilie_pkg::uop_e uop_o,
  output logic           busy_o,
  output logic           done_o
);

  import ilie_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_INS_MOVE = 8'b0000_0100,
    S_INS_PUT  = 8'b0000_1000,
    S_ERS_MOVE = 8'b0001_0000,
    S_ERS_DROP = 8'b0010_0000,
    S_RD_WAIT  = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and micro-operation
  always_comb begin
    state_d = state_q;
    uop_o   = UOP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          uop_o   = UOP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_FINISH;
        if (sts_i.legal) begin
          case (sts_i.cmd)
            CMD_APPEND: uop_o = UOP_APPEND;
            CMD_WRITE:  uop_o = UOP_WRITE;
            CMD_READ: begin
              uop_o   = UOP_READ;
              state_d = S_RD_WAIT;
            end
            CMD_INSERT: begin
              if (sts_i.ins_at_end) begin
                uop_o = UOP_INS_PUT;
              end else begin
                uop_o   = UOP_INS_START;
                state_d = S_INS_MOVE;
              end
            end
            CMD_ERASE: begin
              if (sts_i.ers_at_end) begin
                state_d = S_ERS_DROP;
              end else begin
                uop_o   = UOP_ERS_START;
                state_d = S_ERS_MOVE;
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_INS_MOVE: begin
        uop_o = UOP_INS_MOVE;
        if (sts_i.at_pos) begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        uop_o   = UOP_INS_PUT;
        state_d = S_FINISH;
      end
      S_ERS_MOVE: begin
        uop_o = UOP_ERS_MOVE;
        if (sts_i.at_last) begin
          state_d = S_ERS_DROP;
        end
      end
      S_ERS_DROP: begin
        uop_o   = UOP_ERS_DROP;
        state_d = S_FINISH;
      end
      S_RD_WAIT: begin
        uop_o   = UOP_CAPTURE;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_FINISH);

endmodule
